[rtl/sks_pkg.sv]
// Package for the sorted key set engine: sizes, command and status codes, and the
// control struct from the controller to the datapath. No dependencies.
package sks_pkg;

  localparam int unsigned SET_DEPTH = 64;
  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned POS_W     = $clog2(SET_DEPTH);
  localparam int unsigned CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_FULL        = 3'd2,
    ST_DELETED     = 3'd3,
    ST_DEL_MISS    = 3'd4,
    ST_FOUND       = 3'd5,
    ST_SEARCH_MISS = 3'd6
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } sks_ctl_t;

endpackage

[rtl/sks_ctrl.sv]
// Controller of the sorted key set engine: two-state one-hot machine and the
// output valid flag. Depends on sks_pkg.
module sks_ctrl import sks_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sks_ctl_t ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    ctl_o.load = 1'b0;
    ctl_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/sks_datapath.sv]
// Datapath of the sorted key set engine: a row of compare-and-shift cells, the
// key count, position encoding and the output word register. Depends on sks_pkg.
module sks_datapath import sks_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sks_ctl_t                   ctl_i,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           position_o,
  output logic [CNT_W-1:0]           count_o
);

  logic signed [KEY_BITS-1:0] cells_q [SET_DEPTH];
  logic signed [KEY_BITS-1:0] cells_d [SET_DEPTH];
  logic signed [KEY_BITS-1:0] key_q;
  cmd_e                       cmd_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [STATUS_W-1:0]        status_q;
  logic [POS_W-1:0]           position_q;
  logic [CNT_W-1:0]           out_count_q;

  logic [SET_DEPTH-1:0] less, eq, first;
  logic [POS_W-1:0]     pos;
  logic                 hit, full, do_ins, do_del;
  status_e              status_d;
  logic [POS_W-1:0]     position_d;

  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      less[i] = (CNT_W'(i) < count_q) && (cells_q[i] < key_q);
      eq[i]   = (CNT_W'(i) < count_q) && (cells_q[i] == key_q);
    end
  end

  // The less flags form a thermometer code, so the first clear flag marks the
  // sorted position of the key.
  always_comb begin
    pos = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      first[i] = ((i == 0) ? 1'b1 : less[(i == 0) ? 0 : i - 1]) && !less[i];
      pos      = pos | (first[i] ? POS_W'(i) : '0);
    end
  end

  assign hit    = |eq;
  assign full   = (count_q == CNT_W'(SET_DEPTH));
  assign do_ins = ctl_i.exec && (cmd_q == CMD_INSERT) && !hit && !full;
  assign do_del = ctl_i.exec && (cmd_q == CMD_DELETE) && hit;

  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      cells_d[i] = cells_q[i];
      if (do_ins && !less[i]) begin
        if (first[i]) begin
          cells_d[i] = key_q;
        end else begin
          cells_d[i] = cells_q[(i == 0) ? 0 : i - 1];
        end
      end else if (do_del && !less[i] && (i < SET_DEPTH - 1)) begin
        cells_d[i] = cells_q[(i < SET_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    position_d = '0;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (hit) begin
          status_d = ST_DUPLICATE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d   = ST_INSERTED;
          position_d = pos;
        end
      end
      CMD_DELETE: begin
        status_d = hit ? ST_DELETED : ST_DEL_MISS;
        if (hit) begin
          position_d = pos;
        end
      end
      default: begin
        status_d = hit ? ST_FOUND : ST_SEARCH_MISS;
        if (hit) begin
          position_d = pos;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= key_i;
      cmd_q <= cmd_e'(cmd_i);
    end
    if (ctl_i.exec) begin
      status_q    <= status_d;
      position_q  <= position_d;
      out_count_q <= count_d;
      for (int i = 0; i < SET_DEPTH; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o   = status_q;
  assign position_o = position_q;
  assign count_o    = out_count_q;

endmodule

[rtl/sorted_key_set_engine.sv]
// Top level of the sorted key set engine: joins the controller and the datapath.
// Depends on sks_pkg, sks_ctrl and sks_datapath.
//
// The block holds up to 64 distinct signed 16-bit keys in ascending order.
// The input channel (in_valid_i, in_ready_o) carries one word per item: a
// command (insert, delete or search) in cmd_i and a key in key_i.
// The output channel (out_valid_o, out_ready_i) returns one word per item:
// status_o, position_o (sorted index, zero on duplicate, full or miss) and
// count_o, the number of keys held after the step.
// An item is handled in order: the word is captured in the idle state, and in
// the execute state every cell compares its key with it in parallel and the
// row shifts up or down by one place. The result is written to the output
// register as the execute state ends, and no new word is taken before that.
// If the receiver stalls, the finished result waits in the output register
// while the next word is still accepted; that word then holds in the execute
// state until the output register frees.
// Reset empties the set and drops any result not yet taken; the cells keep
// stale keys, which are never read before they are rewritten.
module sorted_key_set_engine import sks_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           position_o,
  output logic [CNT_W-1:0]           count_o
);

  sks_ctl_t ctl;

  sks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  sks_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .status_o   (status_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

endmodule
